@@ rtl/bvls_pkg.sv @@
// Shared types, codes and widths for the bounded value list store.
package bvls_pkg;

	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned MODE_W   = 2;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned POS_W    = 4;
	localparam int unsigned TOTAL_W  = 5;
	localparam int unsigned LIMIT_W  = 5;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(3);

	// Operation codes carried on the mode field. Code 3 behaves as a find.
	localparam logic [MODE_W-1:0] MODE_INSERT = MODE_W'(0);
	localparam logic [MODE_W-1:0] MODE_REMOVE = MODE_W'(1);
	localparam logic [MODE_W-1:0] MODE_FIND   = MODE_W'(2);

	// Result status codes.
	localparam logic [STATUS_W-1:0] STAT_OK      = STATUS_W'(0);
	localparam logic [STATUS_W-1:0] STAT_FULL    = STATUS_W'(1);
	localparam logic [STATUS_W-1:0] STAT_MISSING = STATUS_W'(2);

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_APPLY
	} seq_state_t;

	// Per-cell control from the sequencer.
	typedef struct packed {
		logic occupied;  // cell holds a live entry
		logic tail;      // cell is the next free slot
		logic capture;   // register the compare result
		logic append;    // write the item value if this is the tail
		logic remove;    // close the gap left by the first match
	} cell_ctrl_t;

endpackage

@@ rtl/bounded_value_list_store_unit.sv @@
// Top level of the bounded value list store: sequencer, cell row and result register.
//
// The block keeps an ordered list of signed 32-bit values in a row of CAPACITY
// cells. An item on the input channel (mode, value) inserts at the tail, removes
// the first equal entry, or finds it; mode 3 acts as find. Each item gives one
// result (status, position, entry_total) on the output channel.
// Both channels use valid/ready; capacity_limit is written through its own
// valid/ready port, which is always ready and should be used only while idle.
// Each item passes through the idle, match and apply states in turn: idle accepts
// it, in match every cell registers its compare, and in apply the first match is
// found along the cell chain and the row shifts or appends. A new item is accepted
// once the previous one has moved into the result register, so the block does not
// take a new item while the previous one is still in the match or apply state.
// If the receiver stalls with a result still held, the next item waits in the
// apply step until the result register frees up.
// Reset empties the list and sets capacity_limit to 3; stored entries are not
// cleared and need no clearing pass.
module bounded_value_list_store_unit
	import bvls_pkg::*;
#(
	parameter int unsigned CAPACITY = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [LIMIT_W-1:0]  capacity_limit,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [MODE_W-1:0]   mode,
	input  logic [VALUE_W-1:0]  value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [POS_W-1:0]    position,
	output logic [TOTAL_W-1:0]  entry_total
);

	// The count field can never exceed what its width holds.
	localparam int unsigned CapClamp = (CAPACITY > 31) ? 31 : CAPACITY;
	localparam logic [TOTAL_W-1:0] CAP_TOTAL = TOTAL_W'(CapClamp);

	seq_state_t          state_q, state_d;
	logic [LIMIT_W-1:0]  limit_q;
	logic [TOTAL_W-1:0]  count_q, count_d;
	logic [MODE_W-1:0]   op_q;
	logic [VALUE_W-1:0]  value_q;

	logic                capture;
	logic                apply_fire;
	logic                full;
	logic                found;
	logic                do_append;
	logic                do_remove;
	logic [POS_W-1:0]    hit_pos;
	logic [STATUS_W-1:0] status_d;
	logic [POS_W-1:0]    pos_d;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [POS_W-1:0]    position_q;
	logic [TOTAL_W-1:0]  total_q;

	logic [VALUE_W-1:0]  entries [CAPACITY];
	logic [CAPACITY:0]   hit_chain;
	logic [CAPACITY-1:0] first_vec;
	cell_ctrl_t          cell_ctrl [CAPACITY];

	// Configuration register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= capacity_limit;
		end
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_MATCH;
			ST_MATCH: state_d = ST_APPLY;
			ST_APPLY: if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready   = 1'b0;
		capture    = 1'b0;
		apply_fire = 1'b0;
		unique case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_MATCH: capture = 1'b1;
			ST_APPLY: apply_fire = !out_valid_q || out_ready;
			default:  in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Latched item.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q    <= mode;
			value_q <= value;
		end
	end

	// Decision on the current item.
	assign full      = (count_q >= TOTAL_W'(limit_q)) || (count_q >= CAP_TOTAL);
	assign found     = hit_chain[CAPACITY];
	assign do_append = apply_fire && (op_q == MODE_INSERT) && !full;
	assign do_remove = apply_fire && (op_q == MODE_REMOVE) && found;

	// First match index from the one-hot flags of the cells.
	always_comb begin
		hit_pos = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (first_vec[i]) begin
				hit_pos = hit_pos | POS_W'(i);
			end
		end
	end

	always_comb begin
		status_d = STAT_OK;
		pos_d    = '0;
		count_d  = count_q;
		if (op_q == MODE_INSERT) begin
			if (full) begin
				status_d = STAT_FULL;
			end else begin
				pos_d   = count_q[POS_W-1:0];
				count_d = count_q + TOTAL_W'(1);
			end
		end else if (!found) begin
			status_d = STAT_MISSING;
		end else begin
			pos_d = hit_pos;
			if (op_q == MODE_REMOVE) begin
				count_d = count_q - TOTAL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (apply_fire) begin
			count_q <= count_d;
		end
	end

	// Result register toward the output channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (apply_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply_fire) begin
			status_q   <= status_d;
			position_q <= pos_d;
			total_q    <= count_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign position    = position_q;
	assign entry_total = total_q;

	// Row of cells; the match flag ripples up and entries shift down.
	assign hit_chain[0] = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic occ;
		logic tail;

		if (i < 32) begin : g_live
			assign occ  = count_q > TOTAL_W'(i);
			assign tail = count_q == TOTAL_W'(i);
		end else begin : g_dead
			assign occ  = 1'b0;
			assign tail = 1'b0;
		end

		assign cell_ctrl[i] = '{
			occupied: occ,
			tail:     tail,
			capture:  capture,
			append:   do_append,
			remove:   do_remove
		};

		bvls_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (cell_ctrl[i]),
			.cmp_value   (value_q),
			.next_entry  ((i + 1 < CAPACITY) ? entries[(i + 1) % CAPACITY] : entries[i]),
			.hit_before  (hit_chain[i]),
			.entry       (entries[i]),
			.hit_through (hit_chain[i+1]),
			.first       (first_vec[i])
		);
	end

	// The list never holds more entries than the row or the count field allows.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_TOTAL)
		else $error("entry count beyond capacity");

	// At most one cell claims to be the first match.
	a_first_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(first_vec))
		else $error("several first-match cells");

	// A full report only comes from an insert.
	a_full_on_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(apply_fire && status_d == STAT_FULL) |-> (op_q == MODE_INSERT))
		else $error("full status on a non-insert item");

	// Error results carry position zero.
	a_err_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != STAT_OK) |-> (position_q == '0))
		else $error("error result with nonzero position");

	// A successful remove shortens the list by one.
	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_remove |=> (count_q == $past(count_q) - TOTAL_W'(1)))
		else $error("remove did not shorten the list");

endmodule

@@ rtl/bvls_cell.sv @@
// One storage cell of the list: an entry, its compare flag and the shift link.
module bvls_cell
	import bvls_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cell_ctrl_t         ctrl,
	input  logic [VALUE_W-1:0] cmp_value,
	input  logic [VALUE_W-1:0] next_entry,
	input  logic               hit_before,
	output logic [VALUE_W-1:0] entry,
	output logic               hit_through,
	output logic               first
);

	logic [VALUE_W-1:0] entry_q;
	logic               hit_q;

	// Compare flag, registered once per item while the store is stable.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctrl.capture) begin
			hit_q <= ctrl.occupied && (entry_q == cmp_value);
		end
	end

	// A match anywhere at or below this cell makes this cell take its neighbor.
	assign hit_through = hit_before | hit_q;
	assign first       = hit_q & ~hit_before;

	// Entry storage: append at the tail, or shift down past the removed entry.
	always_ff @(posedge clk) begin
		if (ctrl.append && ctrl.tail) begin
			entry_q <= cmp_value;
		end else if (ctrl.remove && hit_through) begin
			entry_q <= next_entry;
		end
	end

	assign entry = entry_q;

endmodule

@@ sim/tb_bounded_value_list_store_unit.sv @@
// Self-checking testbench for the bounded value list store: directed and random list traffic.
`timescale 1ns / 1ps

module tb_bounded_value_list_store_unit;
	import bvls_pkg::*;

	localparam int STORE_DEPTH = 16;
	localparam logic [MODE_W-1:0] MODE_SPARE = MODE_W'(3);

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    position;
		logic [TOTAL_W-1:0]  total;
	} list_result_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [LIMIT_W-1:0]  cfg_limit;
	logic                in_valid;
	logic                in_ready;
	logic [MODE_W-1:0]   in_mode;
	logic [VALUE_W-1:0]  in_value;
	logic                out_valid;
	logic                out_ready;
	logic [STATUS_W-1:0] out_status;
	logic [POS_W-1:0]    out_position;
	logic [TOTAL_W-1:0]  out_total;

	// Shadow copy of the list, its fill level and the active limit.
	logic [VALUE_W-1:0] held_vals [STORE_DEPTH];
	int held_count;
	int held_limit;

	list_result_t pending_results [$];

	bit src_idle;
	bit sink_idle;
	int err_count;
	int n_insert, n_remove, n_find, n_full, n_missing, n_limits, peak_count;

	logic [VALUE_W-1:0] value_pool [8] = '{32'h0000_0000, 32'h0000_0001, 32'hffff_ffff,
		32'h8000_0000, 32'h7fff_ffff, 32'd42, 32'hdead_beef, 32'h0000_0100};

	bounded_value_list_store_unit #(
		.CAPACITY(STORE_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.capacity_limit(cfg_limit),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(in_mode),
		.value(in_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(out_status),
		.position(out_position),
		.entry_total(out_total)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Overall time limit for the run.
	initial begin
		#10_000_000;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("end of test: mismatches");
		$finish;
	end

	// Applies one operation to the shadow list and returns the result it should give.
	function automatic list_result_t predict_list_op(logic [MODE_W-1:0] op,
			logic [VALUE_W-1:0] v);
		list_result_t r;
		int hit;
		int eff;
		r.status = STAT_OK;
		r.position = '0;
		eff = (held_limit < STORE_DEPTH) ? held_limit : STORE_DEPTH;
		hit = -1;
		for (int i = held_count - 1; i >= 0; i--) begin
			if (held_vals[i] == v) hit = i;
		end
		if (op == MODE_INSERT) begin
			if (held_count >= eff) begin
				r.status = STAT_FULL;
			end else begin
				r.position = POS_W'(held_count);
				held_vals[held_count] = v;
				held_count++;
			end
		end else if (op == MODE_REMOVE) begin
			if (hit < 0) begin
				r.status = STAT_MISSING;
			end else begin
				r.position = POS_W'(hit);
				for (int i = hit; i < held_count - 1; i++) held_vals[i] = held_vals[i + 1];
				held_count--;
			end
		end else begin
			// Find, and the spare code which behaves the same way.
			if (hit < 0) r.status = STAT_MISSING;
			else r.position = POS_W'(hit);
		end
		r.total = TOTAL_W'(held_count);
		return r;
	endfunction

	task automatic note_mismatch(string what, int got, int want);
		err_count++;
		$display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
	endtask

	// Presents one item, waits for it to be taken, then records what it should produce.
	task automatic send_item(logic [MODE_W-1:0] op, logic [VALUE_W-1:0] v);
		list_result_t r;
		int gap;
		gap = 0;
		if (src_idle && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 18);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			in_mode  <= MODE_W'($urandom);
			in_value <= $urandom;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_mode  <= op;
		in_value <= v;
		do @(posedge clk); while (!in_ready);
		r = predict_list_op(op, v);
		pending_results.push_back(r);
		if (op == MODE_INSERT) n_insert++;
		else if (op == MODE_REMOVE) n_remove++;
		else n_find++;
		if (r.status == STAT_FULL) n_full++;
		if (r.status == STAT_MISSING) n_missing++;
		if (held_count > peak_count) peak_count = held_count;
	endtask

	// Stops sending and waits until every outstanding result has been taken.
	task automatic drain_results();
		@(negedge clk) in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Writes the capacity limit once the block has gone quiet.
	task automatic write_limit(int lim);
		drain_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_limit <= LIMIT_W'(lim);
		do @(posedge clk); while (!cfg_ready);
		held_limit = lim;
		n_limits++;
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	// Mostly values that are likely to hit the list, with some fully random ones.
	function automatic logic [VALUE_W-1:0] pick_value();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 45) return value_pool[$urandom_range(0, 7)];
		if (sel < 75 && held_count > 0) return held_vals[$urandom_range(0, held_count - 1)];
		if (sel < 90) return $urandom;
		return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom_range(0, 3))};
	endfunction

	function automatic logic [MODE_W-1:0] pick_mode(int ins_pct, int rem_pct);
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < ins_pct) return MODE_INSERT;
		if (sel < ins_pct + rem_pct) return MODE_REMOVE;
		return ($urandom_range(0, 3) == 0) ? MODE_SPARE : MODE_FIND;
	endfunction

	// Empty list, duplicates, signed extremes, full at the reset limit, and order after a remove.
	task automatic test_basic_ops();
		send_item(MODE_FIND, 32'h0000_0000);
		send_item(MODE_REMOVE, 32'h0000_0005);
		send_item(MODE_INSERT, 32'h8000_0000);
		send_item(MODE_INSERT, 32'h7fff_ffff);
		send_item(MODE_INSERT, 32'h8000_0000);
		send_item(MODE_INSERT, 32'h0000_0001);
		send_item(MODE_FIND, 32'h8000_0000);
		send_item(MODE_SPARE, 32'h7fff_ffff);
		send_item(MODE_REMOVE, 32'h8000_0000);
		send_item(MODE_FIND, 32'h8000_0000);
		send_item(MODE_INSERT, 32'hffff_ffff);
		send_item(MODE_REMOVE, 32'hffff_ffff);
		send_item(MODE_REMOVE, 32'h1234_5678);
	endtask

	// Limit of zero, a limit above the store size, and a limit below the fill level.
	task automatic test_limit_edges();
		write_limit(0);
		send_item(MODE_INSERT, 32'h0000_0007);
		send_item(MODE_FIND, 32'h7fff_ffff);
		send_item(MODE_REMOVE, 32'h7fff_ffff);
		write_limit(31);
		send_item(MODE_INSERT, 32'h5555_aaaa);
		send_item(MODE_INSERT, 32'haaaa_5555);
		write_limit(1);
		send_item(MODE_INSERT, 32'h0000_0009);
		send_item(MODE_FIND, 32'haaaa_5555);
	endtask

	// Random operations under one limit setting, with occasional full drains.
	task automatic test_random_traffic(int lim, int count, int ins_pct, int rem_pct,
			bit allow_idle);
		write_limit(lim);
		for (int n = 0; n < count; n++) begin
			if (n % 40 == 0) begin
				src_idle  = allow_idle && ($urandom_range(0, 3) != 0);
				sink_idle = allow_idle && ($urandom_range(0, 3) != 0);
			end
			if ($urandom_range(0, 149) == 0) drain_results();
			send_item(pick_mode(ins_pct, rem_pct), pick_value());
		end
	endtask

	// Receiver side: ready stalls in bursts while enabled.
	initial begin : sink_proc
		int stall_left;
		out_ready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (sink_idle && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 18) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Compares each taken result with the oldest expectation.
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				note_mismatch("unexpected result, status", int'(out_status), -1);
			end else begin
				want = pending_results.pop_front();
				if (out_status !== want.status)
					note_mismatch("status", int'(out_status), int'(want.status));
				if (out_position !== want.position)
					note_mismatch("position", int'(out_position), int'(want.position));
				if (out_total !== want.total)
					note_mismatch("entry_total", int'(out_total), int'(want.total));
			end
		end
	end

	// Test sequence.
	initial begin
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_limit  = LIMIT_RESET;
		in_valid   = 1'b0;
		in_mode    = MODE_INSERT;
		in_value   = '0;
		src_idle   = 1'b1;
		sink_idle  = 1'b1;
		held_count = 0;
		held_limit = int'(LIMIT_RESET);
		err_count  = 0;
		n_insert = 0; n_remove = 0; n_find = 0; n_full = 0; n_missing = 0;
		n_limits = 0; peak_count = 0;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_basic_ops();
		test_limit_edges();
		test_random_traffic(16, 220, 60, 20, 1'b1);
		test_random_traffic(31, 200, 50, 25, 1'b1);
		test_random_traffic(1, 200, 30, 40, 1'b1);
		test_random_traffic(16, 200, 70, 10, 1'b1);
		test_random_traffic(0, 150, 40, 35, 1'b1);
		test_random_traffic(5, 200, 45, 35, 1'b1);
		test_random_traffic(9, 200, 50, 30, 1'b1);
		test_random_traffic(17, 150, 55, 25, 1'b1);
		test_random_traffic(2, 100, 45, 40, 1'b1);
		test_random_traffic(16, 100, 50, 30, 1'b0);

		drain_results();
		repeat (10) @(posedge clk);
		if (pending_results.size() != 0)
			note_mismatch("results never delivered", pending_results.size(), 0);

		$display("covered %0d inserts, %0d removes, %0d finds; %0d full, %0d not found",
			n_insert, n_remove, n_find, n_full, n_missing);
		$display("%0d limit writes, deepest list %0d entries, %0d mismatches",
			n_limits, peak_count, err_count);
		if (err_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
